/* design/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types, constants and key ordering functions of the stable merge sorter.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int KEY_W      = 32;
    localparam int TAG_W      = 16;
    localparam int DATA_W     = KEY_W + TAG_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DESCENDING = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_FORMAT = 1'd1;

    // Key format codes.
    localparam logic [1:0] FMT_UNSIGNED = 2'd0;
    localparam logic [1:0] FMT_FLOAT    = 2'd1;
    localparam logic [1:0] FMT_DATE     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic start;
        logic setup;
        logic merge_step;
        logic pass_end;
        logic out_start;
        logic out_load;
    } sms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pass_more;
        logic run_more;
        logic merge_last;
        logic merge_ok;
        logic out_busy;
        logic out_last;
    } sms_stat_t;

    // Maps a key onto an unsigned value whose order is the order of the key.
    function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] key,
                                                     input logic [1:0] fmt);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] v;
        k = key;
        v = key;
        case (fmt) inside
            FMT_FLOAT:
            begin
                // Negative zero sorts as positive zero.
                if (k == {1'b1, {(KEY_W-1){1'b0}}})
                    k = '0;
                if (k[KEY_W-1])
                    v = ~k;
                else
                    v = k | {1'b1, {(KEY_W-1){1'b0}}};
            end
            FMT_UNSIGNED, FMT_DATE:
                v = key;
            default:
                v = key;
        endcase
        return v;
    endfunction

    // True when the left record goes first; ties favor the left record.
    function automatic logic left_first(input logic [KEY_W-1:0] lkey,
                                        input logic [KEY_W-1:0] rkey,
                                        input logic desc,
                                        input logic [1:0] fmt);
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        a = order_value(lkey, fmt);
        b = order_value(rkey, fmt);
        return desc ? (a >= b) : (a <= b);
    endfunction

endpackage

/* design/sms_ctrl.sv */
// ----------------------------------------------------------------------------
// sms_ctrl
// Controller: sequences loading, the merge passes and the result stream.
// ----------------------------------------------------------------------------
module sms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tlast,
    output logic                s_axis_tready,
    input  sms_pkg::sms_stat_t  stat,
    output sms_pkg::sms_cmd_t   cmd
);
    import sms_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_PASS     = 7'b0000010,
        S_SETUP    = 7'b0000100,
        S_MERGE    = 7'b0001000,
        S_NEXT     = 7'b0010000,
        S_OUT_READ = 7'b0100000,
        S_OUT_LOAD = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load_we = accept;
                if (accept && s_axis_tlast)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                if (stat.pass_more)
                    state_next = S_SETUP;
                else
                begin
                    cmd.out_start = 1'b1;
                    state_next    = S_OUT_READ;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge_step = 1'b1;
                if (stat.merge_last)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.run_more)
                    state_next = S_SETUP;
                else
                begin
                    cmd.pass_end = 1'b1;
                    state_next   = S_PASS;
                end
            end
            S_OUT_READ:
            begin
                if (!stat.out_busy)
                    state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = stat.out_last ? S_LOAD : S_OUT_READ;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

/* design/sms_datapath.sv */
// ----------------------------------------------------------------------------
// sms_datapath
// Datapath: record memories, merge pointers, key compare and output register.
// ----------------------------------------------------------------------------
module sms_datapath #(
    parameter int MAX_ITEMS = 64,
    parameter int TAG_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sms_pkg::sms_cmd_t                 cmd,
    output sms_pkg::sms_stat_t                stat,
    input  logic [sms_pkg::DATA_W-1:0]        s_axis_tdata,
    input  logic                              cfg_we,
    input  logic [sms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sms_pkg::DATA_W-1:0]        m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser
);
    import sms_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = AW + 1;
    localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int RW = KEY_W + SW;

    // Record memories, {tag, key}; the sort ping-pongs between the two.
    logic [RW-1:0] mem_a [MAX_ITEMS];
    logic [RW-1:0] mem_b [MAX_ITEMS];

    logic [RW-1:0] rd_al_reg, rd_ar_reg, rd_bl_reg, rd_br_reg;

    logic [CW-1:0] cnt_reg, n_reg, w_reg, lo_reg, i_reg, j_reg, k_reg, mid_reg, hi_reg;
    logic          ovf_reg, ovf_out_reg, bank_reg;
    logic          desc_cfg_reg, desc_reg;
    logic [1:0]    fmt_cfg_reg, fmt_reg;

    logic          out_valid_reg, out_last_reg, out_ovf_reg;
    logic [RW-1:0] out_data_reg;

    logic [RW-1:0] in_rec, dl, dr, wr_rec;
    logic          room, left_ok, right_ok, take_left;
    logic [CW-1:0] i_next, j_next, k_inc;
    logic [CW-1:0] sum_lw, sum_l2w, mid_calc, hi_calc;
    logic [CW-1:0] addr_l, addr_r;
    logic          we_a, we_b;
    logic [AW-1:0] wa_a, wa_b;
    logic [RW-1:0] wd_a;

    assign in_rec = {s_axis_tdata[KEY_W +: SW], s_axis_tdata[KEY_W-1:0]};
    assign room   = cnt_reg < CW'(MAX_ITEMS);

    assign dl = bank_reg ? rd_bl_reg : rd_al_reg;
    assign dr = bank_reg ? rd_br_reg : rd_ar_reg;

    assign left_ok   = i_reg < mid_reg;
    assign right_ok  = j_reg < hi_reg;
    assign take_left = left_ok &&
                       (!right_ok || left_first(dl[KEY_W-1:0], dr[KEY_W-1:0],
                                                desc_reg, fmt_reg));
    assign wr_rec    = take_left ? dl : dr;
    assign i_next    = i_reg + CW'(take_left);
    assign j_next    = j_reg + CW'(!take_left);
    assign k_inc     = k_reg + CW'(1);

    assign sum_lw   = lo_reg + w_reg;
    assign sum_l2w  = lo_reg + {w_reg[CW-2:0], 1'b0};
    assign mid_calc = (sum_lw < n_reg) ? sum_lw : n_reg;
    assign hi_calc  = (sum_l2w < n_reg) ? sum_l2w : n_reg;

    // Reads for the next merge step are issued from the pointers being updated.
    assign addr_l = cmd.setup ? lo_reg : (cmd.merge_step ? i_next : k_reg);
    assign addr_r = cmd.setup ? mid_calc : j_next;

    assign we_a = (cmd.load_we && room) || (cmd.merge_step && bank_reg);
    assign wa_a = cmd.load_we ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign wd_a = cmd.load_we ? in_rec : wr_rec;
    assign we_b = cmd.merge_step && !bank_reg;
    assign wa_b = k_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wa_a] <= wd_a;
        rd_al_reg <= mem_a[addr_l[AW-1:0]];
        rd_ar_reg <= mem_a[addr_r[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[wa_b] <= wr_rec;
        rd_bl_reg <= mem_b[addr_l[AW-1:0]];
        rd_br_reg <= mem_b[addr_r[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            ovf_out_reg   <= 1'b0;
            bank_reg      <= 1'b0;
            w_reg         <= '0;
            lo_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            desc_cfg_reg  <= 1'b0;
            fmt_cfg_reg   <= FMT_UNSIGNED;
            desc_reg      <= 1'b0;
            fmt_reg       <= FMT_UNSIGNED;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_DESCENDING: desc_cfg_reg <= cfg_wdata[0];
                    REG_KEY_FORMAT: fmt_cfg_reg  <= cfg_wdata[1:0];
                    default: ;
                endcase
            end

            if (cmd.load_we && !cmd.start)
            begin
                if (room)
                    cnt_reg <= cnt_reg + CW'(1);
                else
                    ovf_reg <= 1'b1;
            end

            // The final record is counted here as well, so the set size comes
            // from the count as it stands after that record.
            if (cmd.start)
            begin
                n_reg       <= room ? cnt_reg + CW'(1) : cnt_reg;
                ovf_out_reg <= ovf_reg || !room;
                cnt_reg     <= '0;
                ovf_reg     <= 1'b0;
                desc_reg    <= desc_cfg_reg;
                fmt_reg     <= fmt_cfg_reg;
                bank_reg    <= 1'b0;
                w_reg       <= CW'(1);
                lo_reg      <= '0;
            end

            if (cmd.setup)
            begin
                mid_reg <= mid_calc;
                hi_reg  <= hi_calc;
                i_reg   <= lo_reg;
                j_reg   <= mid_calc;
                k_reg   <= lo_reg;
            end

            if (cmd.merge_step)
            begin
                i_reg <= i_next;
                j_reg <= j_next;
                k_reg <= k_inc;
                if (k_inc == hi_reg)
                    lo_reg <= hi_reg;
            end

            if (cmd.pass_end)
            begin
                bank_reg <= !bank_reg;
                w_reg    <= {w_reg[CW-2:0], 1'b0};
                lo_reg   <= '0;
            end

            if (cmd.out_start)
                k_reg <= '0;

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (k_inc == n_reg);
                out_ovf_reg   <= ovf_out_reg;
                k_reg         <= k_inc;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= bank_reg ? rd_bl_reg : rd_al_reg;
    end

    assign stat.pass_more  = w_reg < n_reg;
    assign stat.run_more   = lo_reg < n_reg;
    assign stat.merge_last = (k_inc == hi_reg);
    assign stat.merge_ok   = left_ok || right_ok;
    assign stat.out_busy   = out_valid_reg;
    assign stat.out_last   = (k_inc == n_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {TAG_W'(out_data_reg[RW-1:KEY_W]), out_data_reg[KEY_W-1:0]};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

/* design/stable_merge_sorter.sv */
// ----------------------------------------------------------------------------
// stable_merge_sorter
// Loads a set of keyed records and streams them back out in stable sorted order.
// ----------------------------------------------------------------------------
// Records enter on the s_axis channel, one per cycle while s_axis_tready is
// high; tlast marks the last record of a set. Up to MAX_ITEMS records are kept,
// later ones are dropped and the set is flagged as overflowed.
// After the last record the block runs bottom-up merge passes between two
// record memories; each merged record takes one merge step of the shared
// compare unit, each run adds a setup state and a next state and each pass a
// pass state, and the first result is then read into the output register.
// Results then leave on m_axis one record at a time: the next one is read
// only after the previous one has been taken; tlast marks the last result and tuser
// the overflow flag. A stalled receiver holds the output register and pauses
// the read-out. Loading of the next set starts while the last result waits.
// The cfg port sets the order (index 0) and the key format (index 1); it is
// sampled when the last record of a set arrives.
// Reset empties the sorter and clears both registers; no clearing pass runs.
// ----------------------------------------------------------------------------
module stable_merge_sorter #(
    parameter int MAX_ITEMS = 64,
    parameter int TAG_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sms_pkg::DATA_W-1:0]        s_axis_tdata,  // sort_key, tag
    input  logic                              s_axis_tlast,  // final_item
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sms_pkg::DATA_W-1:0]        m_axis_tdata,  // out_key, out_tag
    output logic                              m_axis_tlast,  // end_of_run
    output logic                              m_axis_tuser,  // overflowed
    input  logic                              cfg_we,
    input  logic [sms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sms_pkg::*;

    sms_cmd_t  cmd;
    sms_stat_t stat;

    sms_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    sms_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .TAG_BITS  (TAG_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded while output register busy");

    // Every merge step has at least one record left in its two runs.
    a_merge_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_step |-> stat.merge_ok)
        else $error("merge step with both runs exhausted");

    // Loading resumes right after the last result enters the output register.
    a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && stat.out_last |=> s_axis_tready)
        else $error("loading did not resume after last result");

    // No record is taken while a set is being sorted.
    a_no_load_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !s_axis_tready)
        else $error("record accepted while sorting");

endmodule
